### hdl/bsa_pkg.sv
package bsa_pkg;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 10;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 2;
    // scan base runs at most three words past the size
    localparam int BASE_W   = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNMARK = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic take_req;    // latch request, arm scan counters
        logic clear_step;  // write one zero word during the clear pass
        logic div_step;    // word estimate from slot index
        logic rd_step;     // correct estimate, read the word
        logic op_step;     // evaluate mark/unmark/test on read word
        logic scan_step;   // one word of the allocate scan
        logic out_load;    // move result into the output register
    } bsa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // clear pass at the last word
        logic scan_done;   // allocate scan found a slot or ran past size
        logic out_free;    // output register can take a result
    } bsa_sts_t;

endpackage

### hdl/bitmap_slot_allocator_core.sv
// First-fit slot allocator over a bitmap of in-use bits.
//
// Request channel (s_valid/s_ready): s_func picks allocate, mark, unmark or
// test; s_slot_index names the slot for the last three. One beat in gives
// exactly one beat out on the result channel (m_valid/m_ready) carrying
// m_status, m_granted_slot and m_slot_set.
// Config channel (cfg_valid/cfg_ready): cfg_bits_in_use sets how many slots
// are managed; write it only while no request is in flight.
//
// Sequence: mark/unmark/test go through index split, word read, update and
// result load before m_valid rises. Allocate reads one map word per cycle
// from the map RAM and stops at the first word with a free bit below size;
// on a full map the scan ends once it runs past size. One request is in
// flight at a time; the next is taken the cycle after its result loads.
//
// Reset: the map RAM is cleared one word per cycle with s_ready low; config
// writes are taken meanwhile.
// Stall: a result held by m_ready low keeps the block from loading the next
// result, so at most one more request is accepted until the stall clears.
module bitmap_slot_allocator_core #(
    parameter int MAX_SLOTS = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bsa_pkg::FUNC_W-1:0]    s_func,
    input  logic [bsa_pkg::IDX_W-1:0]     s_slot_index,
    // result
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bsa_pkg::STATUS_W-1:0]  m_status,
    output logic [bsa_pkg::IDX_W-1:0]     m_granted_slot,
    output logic                          m_slot_set,
    // size register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsa_pkg::SIZE_W-1:0]    cfg_bits_in_use
);

    bsa_pkg::bsa_cmd_t cmd;
    bsa_pkg::bsa_sts_t sts;

    // size register takes a write on any cycle
    assign cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .cmd     (cmd),
        .sts     (sts)
    );

    bsa_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_func          (s_func),
        .s_slot_index    (s_slot_index),
        .cfg_valid       (cfg_valid),
        .cfg_bits_in_use (cfg_bits_in_use),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_granted_slot  (m_granted_slot),
        .m_slot_set      (m_slot_set)
    );

endmodule

### hdl/bsa_dp.sv
module bsa_dp #(
    parameter int MAX_SLOTS = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bsa_pkg::bsa_cmd_t             cmd,
    output bsa_pkg::bsa_sts_t             sts,
    input  logic [bsa_pkg::FUNC_W-1:0]    s_func,
    input  logic [bsa_pkg::IDX_W-1:0]     s_slot_index,
    input  logic                          cfg_valid,
    input  logic [bsa_pkg::SIZE_W-1:0]    cfg_bits_in_use,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [bsa_pkg::STATUS_W-1:0]  m_status,
    output logic [bsa_pkg::IDX_W-1:0]     m_granted_slot,
    output logic                          m_slot_set
);

    localparam int IDX_W     = bsa_pkg::IDX_W;
    localparam int SIZE_W    = bsa_pkg::SIZE_W;
    localparam int BASE_W    = bsa_pkg::BASE_W;
    localparam int FUNC_W    = bsa_pkg::FUNC_W;
    localparam int STATUS_W  = bsa_pkg::STATUS_W;
    localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    // slot / WORD_BITS by reciprocal; estimate is low by at most one
    localparam int RECIP_K   = 16;
    localparam int PROD_W    = IDX_W + RECIP_K + 1;
    localparam logic [RECIP_K:0]    RECIP     = (RECIP_K+1)'((1 << RECIP_K) / WORD_BITS);
    localparam logic [IDX_W-1:0]    WB_IDX    = IDX_W'(WORD_BITS);
    localparam logic [BASE_W-1:0]   WB_BASE   = BASE_W'(WORD_BITS);
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONE_HOT0 = WORD_BITS'(1);

    // map storage
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // request and config
    logic [FUNC_W-1:0]  func_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [SIZE_W-1:0]  bits_in_use_reg, bits_in_use_next;
    logic [SIZE_W-1:0]  size;

    // single-slot path
    logic [PROD_W-1:0]  prod;
    logic [IDX_W-1:0]   qest_reg, qest_next;
    logic [IDX_W-1:0]   qw;
    logic [IDX_W-1:0]   rem;
    logic               rem_hi;
    logic [IDX_W-1:0]   word_idx;
    logic [IDX_W-1:0]   bit_idx;
    logic [ADDR_W-1:0]  word_addr_reg;
    logic [BIT_W-1:0]   bit_pos_reg;
    logic               in_range;
    logic               cur_bit;
    logic               op_write;
    logic [WORD_BITS-1:0] op_mask;
    logic [WORD_BITS-1:0] op_wdata;
    logic [STATUS_W-1:0]  op_status;

    // scan path
    logic [ADDR_W-1:0]  scan_addr_reg, scan_addr_next;
    logic [BASE_W-1:0]  scan_base_reg, scan_base_next;
    logic               eval_valid_reg, eval_valid_next;
    logic [ADDR_W-1:0]  eval_addr_reg;
    logic [BASE_W-1:0]  eval_base_reg;
    logic               past_size;
    logic [BASE_W-1:0]  limit;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]   pos;
    logic               scan_hit;
    logic [IDX_W-1:0]   granted;
    logic [WORD_BITS-1:0] scan_wdata;

    // result staging and output register
    logic [STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]    res_granted_reg;
    logic                res_set_reg;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [IDX_W-1:0]    m_granted_reg;
    logic                m_set_reg;

    // effective size: clamp to capacity
    assign size = (32'(bits_in_use_reg) > MAX_SLOTS) ? SIZE_W'(MAX_SLOTS) : bits_in_use_reg;

    // ---- word/bit split of slot index ----
    assign prod      = PROD_W'(slot_reg) * PROD_W'(RECIP);
    assign qest_next = prod[RECIP_K +: IDX_W];
    assign qw        = qest_reg * WB_IDX;
    assign rem       = slot_reg - qw;
    assign rem_hi    = (rem >= WB_IDX);
    assign word_idx  = rem_hi ? (qest_reg + IDX_W'(1)) : qest_reg;
    assign bit_idx   = rem_hi ? (rem - WB_IDX) : rem;

    assign rd_addr = cmd.rd_step ? ADDR_W'(word_idx) : scan_addr_reg;

    // ---- mark / unmark / test ----
    assign in_range = ({1'b0, slot_reg} < size);
    assign cur_bit  = rdata_reg[bit_pos_reg];
    assign op_mask  = ONE_HOT0 << bit_pos_reg;
    assign op_wdata = (func_reg == bsa_pkg::FUNC_MARK) ? (rdata_reg | op_mask)
                                                       : (rdata_reg & ~op_mask);
    assign op_write = cmd.op_step && in_range &&
                      (((func_reg == bsa_pkg::FUNC_MARK) && !cur_bit) ||
                       ((func_reg == bsa_pkg::FUNC_UNMARK) && cur_bit));

    always_comb begin
        op_status = bsa_pkg::ST_OK;
        if (!in_range) begin
            op_status = bsa_pkg::ST_BAD_INDEX;
        end else begin
            case (func_reg)
                bsa_pkg::FUNC_MARK:   op_status = cur_bit ? bsa_pkg::ST_CONFLICT : bsa_pkg::ST_OK;
                bsa_pkg::FUNC_UNMARK: op_status = cur_bit ? bsa_pkg::ST_OK : bsa_pkg::ST_CONFLICT;
                default:              op_status = bsa_pkg::ST_OK;
            endcase
        end
    end

    // ---- allocate scan: one word per cycle, lowest free bit wins ----
    assign past_size = (eval_base_reg >= BASE_W'(size));
    assign limit     = BASE_W'(size) - eval_base_reg;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            free_bits[i] = !rdata_reg[i] && (BASE_W'(i) < limit);
        end
    end

    always_comb begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                pos = BIT_W'(i);
            end
        end
    end

    assign scan_hit      = cmd.scan_step && eval_valid_reg && !past_size && (|free_bits);
    assign sts.scan_done = cmd.scan_step && eval_valid_reg && (past_size || (|free_bits));
    assign granted       = IDX_W'(eval_base_reg + BASE_W'(pos));
    assign scan_wdata    = rdata_reg | (ONE_HOT0 << pos);

    assign sts.clear_last = (scan_addr_reg == LAST_ADDR);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // ---- memory write port ----
    assign wr_en   = cmd.clear_step || op_write || scan_hit;
    assign wr_addr = cmd.clear_step ? scan_addr_reg : (scan_hit ? eval_addr_reg : word_addr_reg);
    assign wr_data = cmd.clear_step ? '0 : (scan_hit ? scan_wdata : op_wdata);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // ---- control register next values ----
    always_comb begin
        scan_addr_next   = scan_addr_reg;
        scan_base_next   = scan_base_reg;
        eval_valid_next  = eval_valid_reg;
        bits_in_use_next = bits_in_use_reg;
        m_valid_next     = m_valid_reg;
        if (cmd.take_req) begin
            scan_addr_next  = '0;
            scan_base_next  = '0;
            eval_valid_next = 1'b0;
        end else if (cmd.clear_step || cmd.scan_step) begin
            scan_addr_next = scan_addr_reg + ADDR_W'(1);
        end
        if (cmd.scan_step) begin
            scan_base_next  = scan_base_reg + WB_BASE;
            eval_valid_next = 1'b1;
        end
        if (cfg_valid) begin
            bits_in_use_next = cfg_bits_in_use;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg   <= '0;
            scan_base_reg   <= '0;
            eval_valid_reg  <= 1'b0;
            bits_in_use_reg <= bsa_pkg::SIZE_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            scan_addr_reg   <= scan_addr_next;
            scan_base_reg   <= scan_base_next;
            eval_valid_reg  <= eval_valid_next;
            bits_in_use_reg <= bits_in_use_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            func_reg <= s_func;
            slot_reg <= s_slot_index;
        end
        if (cmd.div_step) begin
            qest_reg <= qest_next;
        end
        if (cmd.rd_step) begin
            word_addr_reg <= ADDR_W'(word_idx);
            bit_pos_reg   <= BIT_W'(bit_idx);
        end
        if (cmd.scan_step) begin
            eval_addr_reg <= scan_addr_reg;
            eval_base_reg <= scan_base_reg;
        end
        if (cmd.op_step) begin
            res_status_reg  <= op_status;
            res_granted_reg <= '0;
            res_set_reg     <= in_range && (func_reg == bsa_pkg::FUNC_TEST) && cur_bit;
        end else if (sts.scan_done) begin
            res_status_reg  <= scan_hit ? bsa_pkg::ST_OK : bsa_pkg::ST_FULL;
            res_granted_reg <= scan_hit ? granted : '0;
            res_set_reg     <= 1'b0;
        end
        if (cmd.out_load) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_granted_reg;
            m_set_reg     <= res_set_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_granted_reg;
    assign m_slot_set     = m_set_reg;

`ifndef SYNTHESIS
    a_alloc_sets_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_hit |-> ($countones(wr_data) == $countones(rdata_reg) + 1))
        else $error("allocate write does not add exactly one bit");

    a_unmark_clears_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        op_write && (func_reg == bsa_pkg::FUNC_UNMARK)
            |-> ($countones(wr_data) + 1 == $countones(rdata_reg)))
        else $error("unmark write does not clear exactly one bit");

    a_grant_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_hit |-> ({1'b0, granted} < size))
        else $error("granted slot at or above size");
`endif

endmodule

### hdl/bsa_ctrl.sv
module bsa_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [bsa_pkg::FUNC_W-1:0] s_func,
    output bsa_pkg::bsa_cmd_t          cmd,
    input  bsa_pkg::bsa_sts_t          sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_OP    = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.take_req   = accept;
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.rd_step    = (state_reg == S_RD);
        cmd.op_step    = (state_reg == S_OP);
        cmd.scan_step  = (state_reg == S_SCAN);
        cmd.out_load   = (state_reg == S_RESP) && sts.out_free;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_func == bsa_pkg::FUNC_ALLOC) ? S_SCAN : S_DIV;
                end
            end
            S_DIV:  state_next = S_RD;
            S_RD:   state_next = S_OP;
            S_OP:   state_next = S_RESP;
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_single_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> (state_reg == S_RD) ##1 (state_reg == S_OP)
                                 ##1 (state_reg == S_RESP))
        else $error("single-slot sequence broken");

    a_clear_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) && !sts.clear_last |=> (state_reg == S_CLEAR))
        else $error("clear pass left early");

    a_load_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state_reg == S_IDLE))
        else $error("no return to idle after result load");
`endif

endmodule
